FILE: src/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg: shared types and constants of the message-to-frame segmenter
// Frame layout constants, config register codes and the job word that
// travels from the framing front end to the result emitter.
// ----------------------------------------------------------------------------
package mfs_pkg;

	localparam int FRAME_W   = 64;
	localparam int BYTE_W    = 8;
	localparam int SLOT_W    = 3;
	localparam int SEQ_W     = 4;
	localparam int CFG_IDX_W = 1;

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CALL_HDR  = 1'b0,
		REG_MUSIC_HDR = 1'b1
	} cfg_reg_t;

	// message types
	localparam logic MSG_CALL  = 1'b0;
	localparam logic MSG_MUSIC = 1'b1;

	// last slot of a frame
	localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd7;

	// one job: one or two result words caused by one input byte.
	// the second word, when present, is always a last frame without error.
	typedef struct packed {
		logic [FRAME_W-1:0] d0;
		logic               l0;
		logic               e0;
		logic [FRAME_W-1:0] d1;
		logic               two;
	} job_t;

endpackage

FILE: src/mfs_front.sv
// ----------------------------------------------------------------------------
// mfs_front: framing front end
// Holds the header code registers and the frame under construction; for each
// accepted byte it updates the frame state and builds the job of 0-2 words.
// ----------------------------------------------------------------------------
module mfs_front import mfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	// accepted input word
	input  logic                 accept,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 start_of_message,
	input  logic                 message_type,
	input  logic [2:0]           sub_code,
	input  logic [BYTE_W-1:0]    message_length,
	input  logic [2:0]           batt_level,
	input  logic [2:0]           sig_level,
	// job out
	output logic                 job_push,
	output job_t                 job
);

	logic [BYTE_W-1:0]  call_code_q, music_code_q;
	logic [FRAME_W-1:0] buf_q;
	logic [SLOT_W-1:0]  fill_q;
	logic [BYTE_W-1:0]  rem_q;
	logic [BYTE_W-1:0]  sum_q;
	logic [SEQ_W-1:0]   seq_q;
	logic               chk_q;

	logic [FRAME_W-1:0] buf_d;
	logic [SLOT_W-1:0]  fill_d;
	logic [BYTE_W-1:0]  rem_d;
	logic [BYTE_W-1:0]  sum_d;
	logic [SEQ_W-1:0]   seq_d;
	logic               chk_d;

	// working values
	logic [FRAME_W-1:0] buf_b, buf1;
	logic [SLOT_W-1:0]  fill_b;
	logic [BYTE_W-1:0]  rem_b, rem1, sum_b, sum1, sum_c;
	logic [SEQ_W-1:0]   seq_b;
	logic               chk_b, active;
	logic [4:0]         wc;
	logic [BYTE_W-1:0]  h0c, h1c, h2c, h0m, h1m, cont_hdr;

	// drop byte v into slot s of frame f (slot is known to be empty)
	function automatic logic [FRAME_W-1:0] put_byte(input logic [FRAME_W-1:0] f,
			input logic [SLOT_W-1:0] s, input logic [BYTE_W-1:0] v);
		logic [FRAME_W-1:0] r;
		r = f;
		for (int i = 0; i < 8; i++) begin
			if (s == SLOT_W'(i)) begin
				r[FRAME_W-1-BYTE_W*i -: BYTE_W] = f[FRAME_W-1-BYTE_W*i -: BYTE_W] | v;
			end
		end
		return r;
	endfunction

	// header code registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			call_code_q  <= '0;
			music_code_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CALL_HDR:  call_code_q  <= cfg_data;
				REG_MUSIC_HDR: music_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// header bytes; only word count bits 4..0 reach a header
	always_comb begin
		wc  = message_length[5:1];
		h0c = call_code_q | {5'b0, sub_code};
		h1c = {batt_level, sig_level, wc[4:3]};
		h2c = {wc[2:0], 5'b0};
		h0m = music_code_q;
		h1m = {wc[4:0], sub_code[1:0], 1'b0};
	end

	// frame step
	always_comb begin
		// base state: fresh header on a start, else the running frame
		if (start_of_message) begin
			if (message_type == MSG_CALL) begin
				buf_b  = {h0c, h1c, h2c, 40'b0};
				sum_b  = h0c + h1c + h2c;
				fill_b = 3'd3;
			end else begin
				buf_b  = {h0m, h1m, 48'b0};
				sum_b  = h0m + h1m;
				fill_b = 3'd2;
			end
			rem_b  = message_length;
			seq_b  = SEQ_W'(1);
			chk_b  = 1'b0;
			active = (message_length != '0);
		end else begin
			buf_b  = buf_q;
			sum_b  = sum_q;
			fill_b = fill_q;
			rem_b  = rem_q;
			seq_b  = seq_q;
			chk_b  = chk_q;
			active = (rem_q != '0);
		end

		buf1     = put_byte(buf_b, fill_b, data_byte);
		sum1     = sum_b + data_byte;
		rem1     = rem_b - 8'd1;
		cont_hdr = {seq_b, 4'b0};
		sum_c    = sum1 + cont_hdr;

		buf_d    = buf_q;
		fill_d   = fill_q;
		rem_d    = rem_q;
		sum_d    = sum_q;
		seq_d    = seq_q;
		chk_d    = chk_q;
		job_push = 1'b0;
		job      = '0;

		if (accept) begin
			if (start_of_message && message_length == '0) begin
				// zero length: error word, go idle
				job_push = 1'b1;
				job.e0   = 1'b1;
				buf_d    = '0;
				fill_d   = '0;
				rem_d    = '0;
				chk_d    = 1'b0;
			end else if (active) begin
				if (rem1 == '0) begin
					// message ends here
					job_push = 1'b1;
					job.l0   = 1'b1;
					job.d0   = buf1;
					sum_d    = sum1;
					seq_d    = seq_b;
					if (chk_b) begin
						if (fill_b == SLOT_LAST) begin
							// checksum spills into a frame of its own
							job.l0  = 1'b0;
							job.two = 1'b1;
							job.d1  = {cont_hdr, sum_c, 48'b0};
							sum_d   = sum_c;
							seq_d   = seq_b + SEQ_W'(1);
						end else begin
							job.d0 = put_byte(buf1, fill_b + SLOT_W'(1), sum1);
						end
					end
					buf_d  = '0;
					fill_d = '0;
					rem_d  = '0;
					chk_d  = 1'b0;
				end else if (fill_b == SLOT_LAST) begin
					// frame full: ship it, open continuation
					job_push = 1'b1;
					job.d0   = buf1;
					buf_d    = {cont_hdr, 56'b0};
					sum_d    = sum_c;
					seq_d    = seq_b + SEQ_W'(1);
					fill_d   = 3'd1;
					chk_d    = 1'b1;
					rem_d    = rem1;
				end else begin
					buf_d  = buf1;
					fill_d = fill_b + SLOT_W'(1);
					sum_d  = sum1;
					rem_d  = rem1;
					seq_d  = seq_b;
					chk_d  = chk_b;
				end
			end
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			fill_q <= '0;
			rem_q  <= '0;
			sum_q  <= '0;
			seq_q  <= '0;
			chk_q  <= 1'b0;
		end else begin
			buf_q  <= buf_d;
			fill_q <= fill_d;
			rem_q  <= rem_d;
			sum_q  <= sum_d;
			seq_q  <= seq_d;
			chk_q  <= chk_d;
		end
	end

endmodule

FILE: src/mfs_job_fifo.sv
// ----------------------------------------------------------------------------
// mfs_job_fifo: job queue between front end and emitter
// Small register queue; head entry is presented while not empty.
// ----------------------------------------------------------------------------
module mfs_job_fifo import mfs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic full,
	output logic not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: src/mfs_back.sv
// ----------------------------------------------------------------------------
// mfs_back: result emitter
// Unpacks the head job into one or two result words on the output queue ports.
// ----------------------------------------------------------------------------
module mfs_back import mfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  job_t               job,
	output logic               job_pop,
	input  logic               pop,
	output logic               empty,
	output logic [FRAME_W-1:0] frame_data,
	output logic               last_frame,
	output logic               param_error
);

	logic half_q;   // second word of the head job is showing
	logic take;

	assign empty       = !job_valid;
	assign take        = pop && job_valid;
	assign job_pop     = take && (half_q || !job.two);
	assign frame_data  = half_q ? job.d1 : job.d0;
	assign last_frame  = half_q ? 1'b1 : job.l0;
	assign param_error = half_q ? 1'b0 : job.e0;

	// word select within a job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
		end else if (take) begin
			half_q <= job.two && !half_q;
		end
	end

endmodule

FILE: src/message_to_frame_segmenter_core.sv
// ----------------------------------------------------------------------------
// message_to_frame_segmenter_core: message bytes to 8-byte frames
// Usage:
//   Input queue: drive data_byte and the start fields, raise push while full
//   is low; one byte is taken per cycle while full is low, back to back. Start
//   fields are used only with start_of_message.
//   Result queue: while empty is low the oldest frame is on frame_data,
//   last_frame and param_error; pop takes it.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while the block is idle.
//   A completed frame is written to the job queue and shows when at its head.
//   Throughput: one byte per cycle while full is low; a byte that closes a
//   full frame with a checksum frame yields two words, taken by two pops.
//   The front end and the emitter are split by a JOB_DEPTH entry job queue;
//   full rises only when that queue is full, so a stalled receiver backs
//   pressure up after JOB_DEPTH jobs are waiting.
//   Reset clears the frame state, header codes and queue; no clearing pass.
// ----------------------------------------------------------------------------
module message_to_frame_segmenter_core import mfs_pkg::*; #(
	parameter int JOB_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	// input queue
	input  logic                 push,
	output logic                 full,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 start_of_message,
	input  logic                 message_type,
	input  logic [2:0]           sub_code,
	input  logic [BYTE_W-1:0]    message_length,
	input  logic [2:0]           batt_level,
	input  logic [2:0]           sig_level,
	// result queue
	output logic                 empty,
	input  logic                 pop,
	output logic [FRAME_W-1:0]   frame_data,
	output logic                 last_frame,
	output logic                 param_error
);

	logic accept, job_push, job_pop, job_full, job_valid;
	job_t job_in, job_head;

	assign cfg_ready = 1'b1;
	assign full      = job_full;
	assign accept    = push && !job_full;

	mfs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.accept           (accept),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.message_type     (message_type),
		.sub_code         (sub_code),
		.message_length   (message_length),
		.batt_level       (batt_level),
		.sig_level        (sig_level),
		.job_push         (job_push),
		.job              (job_in)
	);

	mfs_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.wdata     (job_in),
		.pop       (job_pop),
		.rdata     (job_head),
		.full      (job_full),
		.not_empty (job_valid)
	);

	mfs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (job_head),
		.job_pop     (job_pop),
		.pop         (pop),
		.empty       (empty),
		.frame_data  (frame_data),
		.last_frame  (last_frame),
		.param_error (param_error)
	);

	// error word is never a frame
	a_err_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && param_error) |-> (!last_frame && frame_data == '0))
		else $error("error word carries frame content");

	// a two-word job starts with a plain continuation frame
	a_two_first_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(job_push && job_in.two) |-> (!job_in.l0 && !job_in.e0))
		else $error("two-word job with bad first word");

	// jobs are only generated for accepted bytes
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> accept)
		else $error("job generated without an accepted byte");

endmodule

FILE: verif/mfs_checker.sv
// ----------------------------------------------------------------------------
// mfs_checker: frame predictor and result checker for the segmenter core
// Watches the config, input and result channels. Every accepted input word
// is run through a local copy of the framing logic and the frames it yields
// are queued; every popped word is compared field by field with the oldest
// queued frame. Hands the mismatch count and the number of frames still owed
// to the testbench top.
// ----------------------------------------------------------------------------
module mfs_checker import mfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 push,
	input  logic                 full,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 start_of_message,
	input  logic                 message_type,
	input  logic [2:0]           sub_code,
	input  logic [BYTE_W-1:0]    message_length,
	input  logic [2:0]           batt_level,
	input  logic [2:0]           sig_level,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [FRAME_W-1:0]   frame_data,
	input  logic                 last_frame,
	input  logic                 param_error,
	output int                   mismatch_count,
	output int                   frames_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [FRAME_W-1:0] data;
		logic               last;
		logic               err;
	} frame_word_t;

	frame_word_t owed_frames[$];

	// header codes as last written
	logic [BYTE_W-1:0]  call_code;
	logic [BYTE_W-1:0]  music_code;

	// framing state
	logic [FRAME_W-1:0] frame_acc;
	logic [SLOT_W-1:0]  next_slot;
	logic [BYTE_W-1:0]  bytes_left;
	logic [BYTE_W-1:0]  check_sum;
	logic [SEQ_W-1:0]   seq_no;
	logic               in_continuation;

	function automatic logic [FRAME_W-1:0] place_byte(input logic [FRAME_W-1:0] frame,
			input logic [SLOT_W-1:0] slot, input logic [BYTE_W-1:0] v);
		return frame | ({56'd0, v} << (int'(SLOT_LAST - slot) * 8));
	endfunction

	task automatic drop_message();
		frame_acc       = '0;
		next_slot       = '0;
		bytes_left      = '0;
		in_continuation = 1'b0;
	endtask

	task automatic queue_frame(input logic [FRAME_W-1:0] d, input logic l, input logic e);
		owed_frames.push_back('{data: d, last: l, err: e});
	endtask

	// open the next continuation frame: sequence nibble in byte 0
	task automatic open_continuation();
		logic [BYTE_W-1:0] seq_hdr;
		seq_hdr         = {seq_no, 4'h0};
		frame_acc       = place_byte('0, 3'd0, seq_hdr);
		check_sum       = check_sum + seq_hdr;
		seq_no          = seq_no + 1'b1;
		next_slot       = 3'd1;
		in_continuation = 1'b1;
	endtask

	// one accepted input word through the framing logic
	task automatic segment_byte(input logic [BYTE_W-1:0] b, input logic som,
			input logic mtype, input logic [2:0] sub, input logic [BYTE_W-1:0] len,
			input logic [2:0] bat, input logic [2:0] sig);
		logic [BYTE_W-1:0] wc;
		logic [BYTE_W-1:0] h0;
		logic [BYTE_W-1:0] h1;
		logic [BYTE_W-1:0] h2;
		logic [SLOT_W-1:0] slot;
		if (som) begin
			wc = len >> 1;
			drop_message();
			if (len == 8'd0) begin
				queue_frame('0, 1'b0, 1'b1);
				return;
			end
			if (mtype == MSG_CALL) begin
				h0        = call_code | {5'd0, sub};
				h1        = {bat, sig, wc[4:3]};
				h2        = {wc[2:0], 5'd0};
				frame_acc = place_byte(place_byte(place_byte('0, 3'd0, h0), 3'd1, h1), 3'd2, h2);
				check_sum = h0 + h1 + h2;
				next_slot = 3'd3;
			end else begin
				h0        = music_code;
				h1        = {wc[4:0], sub[1:0], 1'b0};
				frame_acc = place_byte(place_byte('0, 3'd0, h0), 3'd1, h1);
				check_sum = h0 + h1;
				next_slot = 3'd2;
			end
			bytes_left = len;
			seq_no     = 4'd1;
		end else if (bytes_left == 8'd0) begin
			return;
		end

		slot       = next_slot;
		frame_acc  = place_byte(frame_acc, slot, b);
		check_sum  = check_sum + b;
		bytes_left = bytes_left - 1'b1;

		if (bytes_left == 8'd0) begin
			if (in_continuation) begin
				// checksum after the data, or alone when the frame is full
				if (slot == SLOT_LAST) begin
					queue_frame(frame_acc, 1'b0, 1'b0);
					open_continuation();
					frame_acc = place_byte(frame_acc, 3'd1, check_sum);
				end else begin
					frame_acc = place_byte(frame_acc, slot + 1'b1, check_sum);
				end
			end
			queue_frame(frame_acc, 1'b1, 1'b0);
			drop_message();
		end else if (slot == SLOT_LAST) begin
			queue_frame(frame_acc, 1'b0, 1'b0);
			open_continuation();
		end else begin
			next_slot = slot + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_word_t want;
		if (!arst_n) begin
			call_code      = '0;
			music_code     = '0;
			check_sum      = '0;
			seq_no         = '0;
			drop_message();
			owed_frames.delete();
			mismatch_count = 0;
			frames_owed    = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_CALL_HDR: begin
						call_code = cfg_data;
					end
					REG_MUSIC_HDR: begin
						music_code = cfg_data;
					end
					default: begin
					end
				endcase
			end

			// accepted input word
			if (push && !full)
				segment_byte(data_byte, start_of_message, message_type, sub_code,
					message_length, batt_level, sig_level);

			// accepted result word
			if (pop && !empty) begin
				if (owed_frames.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected word frame_data=%h last=%b err=%b",
						$realtime, frame_data, last_frame, param_error);
				end else begin
					want = owed_frames.pop_front();
					if (frame_data !== want.data) begin
						mismatch_count++;
						$display("%0t: frame_data expected %h actual %h",
							$realtime, want.data, frame_data);
					end
					if (last_frame !== want.last) begin
						mismatch_count++;
						$display("%0t: last_frame expected %b actual %b",
							$realtime, want.last, last_frame);
					end
					if (param_error !== want.err) begin
						mismatch_count++;
						$display("%0t: param_error expected %b actual %b",
							$realtime, want.err, param_error);
					end
				end
			end
			frames_owed = owed_frames.size();
		end
	end

endmodule

FILE: verif/tb_message_to_frame_segmenter_core.sv
// ----------------------------------------------------------------------------
// tb_message_to_frame_segmenter_core: testbench top of the segmenter core
// Resets the core, writes the header codes, then feeds directed messages
// (zero length, short, exactly full, spill, lone checksum frame, restart,
// stray byte) and random message traffic over four idle/stall phases. A
// separate checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_message_to_frame_segmenter_core import mfs_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_ITEMS = 200;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 10;

	// data fill patterns for message bodies
	localparam logic [1:0] FILL_RANDOM = 2'd0;
	localparam logic [1:0] FILL_ZERO   = 2'd1;
	localparam logic [1:0] FILL_ONES   = 2'd2;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 push;
	logic                 full;
	logic [BYTE_W-1:0]    data_byte;
	logic                 start_of_message;
	logic                 message_type;
	logic [2:0]           sub_code;
	logic [BYTE_W-1:0]    message_length;
	logic [2:0]           batt_level;
	logic [2:0]           sig_level;
	logic                 empty;
	logic                 pop;
	logic [FRAME_W-1:0]   frame_data;
	logic                 last_frame;
	logic                 param_error;

	int mismatch_count;
	int frames_owed;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int phase_items;

	message_to_frame_segmenter_core DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.message_type     (message_type),
		.sub_code         (sub_code),
		.message_length   (message_length),
		.batt_level       (batt_level),
		.sig_level        (sig_level),
		.empty            (empty),
		.pop              (pop),
		.frame_data       (frame_data),
		.last_frame       (last_frame),
		.param_error      (param_error)
	);

	mfs_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.message_type     (message_type),
		.sub_code         (sub_code),
		.message_length   (message_length),
		.batt_level       (batt_level),
		.sig_level        (sig_level),
		.empty            (empty),
		.pop              (pop),
		.frame_data       (frame_data),
		.last_frame       (last_frame),
		.param_error      (param_error),
		.mismatch_count   (mismatch_count),
		.frames_owed      (frames_owed)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int n;
		pop <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				n            = hold_request;
				hold_request = 0;
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
				@(posedge clk);
			end
		end
	end

	// one input word; returns after the edge that accepts it
	task automatic send_word(input logic [BYTE_W-1:0] b, input logic som, input logic mtype,
			input logic [2:0] sub, input logic [BYTE_W-1:0] len, input logic [2:0] bat,
			input logic [2:0] sig);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push             <= 1'b1;
		data_byte        <= b;
		start_of_message <= som;
		message_type     <= mtype;
		sub_code         <= sub;
		message_length   <= len;
		batt_level       <= bat;
		sig_level        <= sig;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		phase_items++;
	endtask

	// a message of len bytes, of which only the first nbytes are sent
	task automatic send_message(input logic mtype, input logic [2:0] sub,
			input logic [BYTE_W-1:0] len, input logic [2:0] bat, input logic [2:0] sig,
			input int nbytes, input logic [1:0] fill);
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < nbytes || (i == 0 && len == 8'd0); i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom);
			endcase
			if (i == 0)
				send_word(b, 1'b1, mtype, sub, len, bat, sig);
			else
				// header fields are don't-care here: keep them noisy
				send_word(b, 1'b0, 1'($urandom), 3'($urandom), 8'($urandom),
					3'($urandom), 3'($urandom));
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] v);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, let every owed frame drain, then idle with push low
	task automatic drain();
		push <= 1'b0;
		do @(negedge clk); while (frames_owed != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// random message traffic until the phase has enough words
	task automatic random_traffic();
		int r;
		int len;
		int nbytes;
		phase_items = 0;
		while (phase_items < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 5) begin
				len = 0;
			end else if (r < 9) begin
				len = $urandom_range(255, 100);
			end else if (r < 14) begin
				// stray word without start
				send_word(8'($urandom), 1'b0, 1'($urandom), 3'($urandom), 8'($urandom),
					3'($urandom), 3'($urandom));
				continue;
			end else begin
				len = $urandom_range(30, 1);
			end
			nbytes = len;
			if (len > 1 && $urandom_range(99) < 8)
				nbytes = $urandom_range(len - 1, 1);
			send_message(1'($urandom), 3'($urandom), 8'(len), 3'($urandom), 3'($urandom),
				nbytes, FILL_RANDOM);
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_valid        <= 1'b0;
		cfg_index        <= REG_CALL_HDR;
		cfg_data         <= '0;
		push             <= 1'b0;
		data_byte        <= '0;
		start_of_message <= 1'b0;
		message_type     <= MSG_CALL;
		sub_code         <= '0;
		message_length   <= '0;
		batt_level       <= '0;
		sig_level        <= '0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		hold_request     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: header codes with low bits set so the subtype OR shows
		write_reg(REG_CALL_HDR, 8'hA5);
		write_reg(REG_MUSIC_HDR, 8'h5A);
		send_message(MSG_CALL, 3'd7, 8'd0, 3'd7, 3'd7, 1, FILL_RANDOM);
		send_message(MSG_MUSIC, 3'd3, 8'd0, 3'd0, 3'd0, 1, FILL_RANDOM);
		send_message(MSG_CALL, 3'd0, 8'd1, 3'd0, 3'd0, 1, FILL_ONES);
		// call spilling one byte into a continuation frame
		send_message(MSG_CALL, 3'd7, 8'd6, 3'd7, 3'd7, 6, FILL_ZERO);
		// music filling its first frame exactly: no checksum
		send_message(MSG_MUSIC, 3'd7, 8'd6, 3'd5, 3'd2, 6, FILL_ONES);
		// call whose checksum lands in a frame of its own
		send_message(MSG_CALL, 3'd2, 8'd12, 3'd1, 3'd6, 12, FILL_RANDOM);
		// stray word while idle
		send_word(8'hFF, 1'b0, MSG_MUSIC, 3'd7, 8'hFF, 3'd7, 3'd7);
		// restart mid-message, then a short message
		send_message(MSG_MUSIC, 3'd1, 8'd10, 3'd0, 3'd0, 3, FILL_RANDOM);
		send_message(MSG_CALL, 3'd5, 8'd2, 3'd3, 3'd4, 2, FILL_RANDOM);
		drain();

		// random phases: idle/stall mix and header codes change per phase
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					write_reg(REG_CALL_HDR, 8'h00);
					write_reg(REG_MUSIC_HDR, 8'hFF);
					hold_request = LONG_HOLD;
				end
				1: begin
					send_idle_pct  = 71;
					recv_stall_pct = 0;
					write_reg(REG_CALL_HDR, 8'hFF);
					write_reg(REG_MUSIC_HDR, 8'h00);
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 71;
					write_reg(REG_CALL_HDR, 8'($urandom));
					write_reg(REG_MUSIC_HDR, 8'($urandom));
				end
				default: begin
					send_idle_pct  = 22;
					recv_stall_pct = 22;
					write_reg(REG_CALL_HDR, 8'($urandom));
					write_reg(REG_MUSIC_HDR, 8'($urandom));
				end
			endcase
			random_traffic();
			drain();
		end

		if (mismatch_count == 0 && frames_owed == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: message_to_frame_segmenter_core.f
src/mfs_pkg.sv
src/mfs_front.sv
src/mfs_job_fifo.sv
src/mfs_back.sv
src/message_to_frame_segmenter_core.sv
verif/mfs_checker.sv
verif/tb_message_to_frame_segmenter_core.sv
